@@ design/bfm_pkg.sv @@
// Shared constants for the box filter mean core.
package bfm_pkg;

   // Fixed field widths
   localparam int PIX_W    = 8;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int WIN_W    = 4;
   localparam int ROW_W    = 12;
   localparam int CSUM_W   = 12;
   localparam int WSUM_W   = 16;
   localparam int AREA_W   = 8;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 2;

   // Slot count follows the window register width
   localparam int SLOT_DEPTH = 2 ** WIN_W;

   // Maximum image height
   localparam int MAX_HEIGHT = 4096;

   // Queue entry bits beyond the column index
   localparam int ENT_FIXED_W = PIX_W + 3 * WIN_W + 6;

   // Defaults for the top level parameters
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_WINDOW = 15;

   // Reset values of the configuration registers
   localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
   localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
   localparam logic [WIN_W-1:0]    RST_WINDOW = 4'd3;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_WINDOW = 2'd2
   } reg_index_type;

endpackage

@@ design/box_filter_mean_core.sv @@
// Box filter mean core: configuration registers, front, queue and back.
//
// Takes 8-bit grayscale pixels in raster order on the req_ stream; req_tuser
// marks the first pixel of a frame. For every window_size x window_size
// window wholly inside the image it returns the truncated window mean on the
// rsp_ stream, with rsp_tlast on the last result of the frame.
// The front takes one pixel, forms row and column slots one position bit at
// a time (12 bits at the default width), and queues it if the window is nonzero.
// The back takes one request at a time: it updates the sums and, for a pixel
// with a result, runs the 16-step serial divider and loads the output
// register before it takes the next request. A result passes the queue,
// the sum update, the divider and the output register on its way out.
// After reset all MAX_WIDTH entries of the column sum memory are swept to
// zero, during which req_tready stays low; csr_ writes are taken at any time.
// When the receiver stalls, the result waits in the output register, the
// front keeps accepting until the two-entry queue fills.
module box_filter_mean_core
   import bfm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIX_W-1:0]     req_tdata,   // [7:0] pixel
   input  logic                 req_tuser,   // [0] frame_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_W-1:0]     rsp_tdata,   // [7:0] mean_value
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int ENT_W = XW + ENT_FIXED_W;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIN_W-1:0]    window_ff;
   logic                clear_busy;
   logic                q_full, q_empty, q_push, q_pop;
   logic [ENT_W-1:0]    q_in, q_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         window_ff <= RST_WINDOW;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            REG_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            REG_WINDOW: window_ff <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   bfm_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WINDOW(MAX_WINDOW),
      .XW        (XW),
      .ENT_W     (ENT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg_width (width_ff),
      .cfg_height(height_ff),
      .cfg_window(window_ff),
      .clear_busy(clear_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   bfm_queue #(
      .DATA_W(ENT_W),
      .DEPTH (2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .pop      (q_pop),
      .pop_data (q_out),
      .full     (q_full),
      .empty    (q_empty)
   );

   bfm_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WINDOW(MAX_WINDOW),
      .XW        (XW),
      .ENT_W     (ENT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .clear_busy(clear_busy),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // No pixel is taken during the clearing sweep
   assert property (@(posedge clock) disable iff (reset) clear_busy |-> !req_tready)
      else $error("request accepted during clearing sweep");

   // Reset starts the clearing sweep
   assert property (@(posedge clock) reset |=> clear_busy)
      else $error("clearing sweep not started after reset");

   // The front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("push into full queue");

   // The back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) !(q_pop && q_empty))
      else $error("pop from empty queue");

endmodule

@@ design/bfm_queue.sv @@
// Small request queue between the front and back parts.
module bfm_queue
   import bfm_pkg::*;
#(
   parameter int DATA_W = 36,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/bfm_front.sv @@
// Front part: accepts pixels, tracks the position and classifies each request.
module bfm_front
   import bfm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int XW         = $clog2(MAX_WIDTH),
   parameter int ENT_W      = XW + ENT_FIXED_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PIX_W-1:0]    req_tdata,
   input  logic                req_tuser,
   input  logic [WIDTH_W-1:0]  cfg_width,
   input  logic [HEIGHT_W-1:0] cfg_height,
   input  logic [WIN_W-1:0]    cfg_window,
   input  logic                clear_busy,
   input  logic                q_full,
   output logic                q_push,
   output logic [ENT_W-1:0]    q_data
);

   localparam int XW1   = XW + 1;
   localparam int MOD_W = (XW > ROW_W) ? XW : ROW_W;
   localparam int MCW   = $clog2(MOD_W + 1);

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [XW-1:0]    x;
      logic [WIN_W-1:0] rslot;
      logic [WIN_W-1:0] cslot;
      logic [WIN_W-1:0] win;
      logic             r_zero;
      logic             r_ge;
      logic             x_zero;
      logic             x_ge;
      logic             emit;
      logic             last;
   } entry_type;

   typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} state_type;

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [XW-1:0]     col_pos_ff, col_pos_in;
   entry_type         ent_ff, ent_in;
   logic [MOD_W-1:0]  rbits_ff, rbits_in;
   logic [MOD_W-1:0]  xbits_ff, xbits_in;
   logic [WIN_W-1:0]  rrem_ff, rrem_in;
   logic [WIN_W-1:0]  crem_ff, crem_in;
   logic [MCW-1:0]    mcnt_ff, mcnt_in;

   logic [XW1-1:0]      w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [WIN_W-1:0]    win_eff;
   logic [HEIGHT_W-1:0] r_a;
   logic [XW1-1:0]      x_a;
   logic [WIN_W:0]      rstep, cstep;
   logic                accept;

   // Clamp the configuration to its usable range
   always_comb begin
      if (cfg_width == '0) begin
         w_eff = XW1'(1);
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         w_eff = XW1'(MAX_WIDTH);
      end else begin
         w_eff = XW1'(cfg_width);
      end
      if (cfg_height == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (32'(cfg_height) > MAX_HEIGHT) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg_height;
      end
      if (32'(cfg_window) > MAX_WINDOW) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = cfg_window;
      end
   end

   assign req_tready = (state_ff == F_IDLE) && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   // Place the incoming pixel: frame start, row wrap and frame wrap
   always_comb begin
      r_a = req_tuser ? '0 : HEIGHT_W'(row_pos_ff);
      x_a = req_tuser ? '0 : XW1'(col_pos_ff);
      if (x_a >= w_eff) begin
         x_a = '0;
         r_a = r_a + 1'b1;
      end
      if (r_a >= h_eff) begin
         r_a = '0;
      end
   end

   // One remainder step for row and column slots
   always_comb begin
      rstep = {rrem_ff, rbits_ff[MOD_W-1]};
      if (rstep >= (WIN_W+1)'(ent_ff.win)) begin
         rstep = rstep - (WIN_W+1)'(ent_ff.win);
      end
      cstep = {crem_ff, xbits_ff[MOD_W-1]};
      if (cstep >= (WIN_W+1)'(ent_ff.win)) begin
         cstep = cstep - (WIN_W+1)'(ent_ff.win);
      end
   end

   // Sequence accept, slot remainder and push
   always_comb begin
      state_in   = state_ff;
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      ent_in     = ent_ff;
      rbits_in   = rbits_ff;
      xbits_in   = xbits_ff;
      rrem_in    = rrem_ff;
      crem_in    = crem_ff;
      mcnt_in    = mcnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               // Advance position for the next pixel
               if (x_a + 1'b1 >= w_eff) begin
                  col_pos_in = '0;
                  row_pos_in = (r_a + 1'b1 >= h_eff) ? '0 : ROW_W'(r_a + 1'b1);
               end else begin
                  col_pos_in = XW'(x_a + 1'b1);
                  row_pos_in = ROW_W'(r_a);
               end
               // Classify; with a zero window the request is not queued
               ent_in.pix    = req_tdata;
               ent_in.x      = XW'(x_a);
               ent_in.win    = win_eff;
               ent_in.rslot  = '0;
               ent_in.cslot  = '0;
               ent_in.r_zero = (r_a == '0);
               ent_in.r_ge   = (r_a >= HEIGHT_W'(win_eff));
               ent_in.x_zero = (x_a == '0);
               ent_in.x_ge   = (x_a >= XW1'(win_eff));
               ent_in.emit   = (XW1'(win_eff) <= w_eff) && (HEIGHT_W'(win_eff) <= h_eff)
                               && (r_a + 1'b1 >= HEIGHT_W'(win_eff))
                               && (x_a + 1'b1 >= XW1'(win_eff));
               ent_in.last   = (r_a + 1'b1 == h_eff) && (x_a + 1'b1 == w_eff);
               rbits_in      = MOD_W'(r_a);
               xbits_in      = MOD_W'(x_a);
               rrem_in       = '0;
               crem_in       = '0;
               mcnt_in       = '0;
               if (win_eff != '0) begin
                  state_in = F_MOD;
               end
            end
         end
         F_MOD: begin
            rrem_in  = WIN_W'(rstep);
            crem_in  = WIN_W'(cstep);
            rbits_in = {rbits_ff[MOD_W-2:0], 1'b0};
            xbits_in = {xbits_ff[MOD_W-2:0], 1'b0};
            mcnt_in  = mcnt_ff + 1'b1;
            if (mcnt_ff == MCW'(MOD_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         mcnt_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
         mcnt_ff    <= mcnt_in;
      end
      ent_ff   <= ent_in;
      rbits_ff <= rbits_in;
      xbits_ff <= xbits_in;
      rrem_ff  <= rrem_in;
      crem_ff  <= crem_in;
   end

   // Hand the classified request to the queue
   always_comb begin
      q_data = ent_ff;
      q_data[ENT_W-PIX_W-XW-1 -: WIN_W]         = rrem_ff;
      q_data[ENT_W-PIX_W-XW-WIN_W-1 -: WIN_W]   = crem_ff;
   end
   assign q_push = (state_ff == F_PUSH) && !q_full;

endmodule

@@ design/bfm_back.sv @@
// Back part: updates column and window sums, divides by the area, drives results.
module bfm_back
   import bfm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int XW         = $clog2(MAX_WIDTH),
   parameter int ENT_W      = XW + ENT_FIXED_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  logic [ENT_W-1:0] q_data,
   output logic             q_pop,
   output logic             clear_busy,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int RS_DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int RS_AW    = $clog2(RS_DEPTH);
   localparam int DCW      = $clog2(WSUM_W + 1);

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [XW-1:0]    x;
      logic [WIN_W-1:0] rslot;
      logic [WIN_W-1:0] cslot;
      logic [WIN_W-1:0] win;
      logic             r_zero;
      logic             r_ge;
      logic             x_zero;
      logic             x_ge;
      logic             emit;
      logic             last;
   } entry_type;

   typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_CALC, B_DIV, B_PUT} state_type;

   state_type          state_ff, state_in;
   entry_type          ent_ff, ent_in;
   entry_type          q_ent;
   logic [XW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [CSUM_W-1:0]  recent_ff [SLOT_DEPTH];
   logic [WSUM_W-1:0]  dvd_ff, dvd_in;
   logic [AREA_W-1:0]  rem_ff, rem_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CSUM_W-1:0]  col_mem [MAX_WIDTH];
   logic [PIX_W-1:0]   row_mem [RS_DEPTH];
   logic [CSUM_W-1:0]  col_rd_ff;
   logic [PIX_W-1:0]   row_rd_ff;
   logic               col_we;
   logic [XW-1:0]      col_waddr;
   logic [CSUM_W-1:0]  col_wdata;
   logic               row_we;
   logic [RS_AW-1:0]   row_waddr, row_raddr;

   logic [CSUM_W-1:0]  cs;
   logic [WSUM_W-1:0]  wsum_new;
   logic [AREA_W:0]    dstep;
   logic               out_free;

   assign q_ent      = entry_type'(q_data);
   assign clear_busy = (state_ff == B_CLEAR);
   assign q_pop      = (state_ff == B_IDLE) && !q_empty;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign row_raddr = RS_AW'(RS_AW'(q_ent.rslot) * RS_AW'(MAX_WIDTH)) + RS_AW'(q_ent.x);
   assign row_waddr = RS_AW'(RS_AW'(ent_ff.rslot) * RS_AW'(MAX_WIDTH)) + RS_AW'(ent_ff.x);

   // Column sum and window sum of the current request
   always_comb begin
      if (ent_ff.r_zero) begin
         cs = CSUM_W'(ent_ff.pix);
      end else begin
         cs = col_rd_ff + CSUM_W'(ent_ff.pix) - (ent_ff.r_ge ? CSUM_W'(row_rd_ff) : '0);
      end
      if (ent_ff.x_zero) begin
         wsum_new = WSUM_W'(cs);
      end else begin
         wsum_new = wsum_ff + WSUM_W'(cs)
                    - (ent_ff.x_ge ? WSUM_W'(recent_ff[ent_ff.cslot]) : '0);
      end
   end

   // Memory write ports
   always_comb begin
      col_we    = 1'b0;
      col_waddr = ent_ff.x;
      col_wdata = cs;
      row_we    = (state_ff == B_CALC);
      if (state_ff == B_CLEAR) begin
         col_we    = 1'b1;
         col_waddr = clr_cnt_ff;
         col_wdata = '0;
      end else if (state_ff == B_CALC) begin
         col_we = 1'b1;
      end
   end

   // One restoring division step
   always_comb begin
      dstep = {rem_ff, dvd_ff[WSUM_W-1]};
      if (dstep >= (AREA_W+1)'(area_ff)) begin
         dstep = dstep - (AREA_W+1)'(area_ff);
      end
   end

   // Sequence clear pass, update, divide and output
   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      clr_cnt_in   = clr_cnt_ff;
      wsum_in      = wsum_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      area_in      = area_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         B_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == XW'(MAX_WIDTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               ent_in   = q_ent;
               state_in = B_CALC;
            end
         end
         B_CALC: begin
            wsum_in  = wsum_new;
            dvd_in   = wsum_new;
            rem_in   = '0;
            dcnt_in  = '0;
            area_in  = AREA_W'(ent_ff.win) * AREA_W'(ent_ff.win);
            state_in = ent_ff.emit ? B_DIV : B_IDLE;
         end
         B_DIV: begin
            rem_in  = AREA_W'(dstep);
            dvd_in  = {dvd_ff[WSUM_W-2:0], (dstep != {rem_ff, dvd_ff[WSUM_W-1]})};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(WSUM_W - 1)) begin
               state_in = B_PUT;
            end
         end
         B_PUT: begin
            // Saturate the quotient and load the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (dvd_ff > WSUM_W'(255)) ? 8'hFF : dvd_ff[PIX_W-1:0];
               rsp_last_in  = ent_ff.last;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_cnt_ff   <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         wsum_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         wsum_ff      <= wsum_in;
      end
      ent_ff      <= ent_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      area_ff     <= area_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Recent column sums of the row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_DEPTH; i++) begin
            recent_ff[i] <= '0;
         end
      end else if (state_ff == B_CALC) begin
         recent_ff[ent_ff.cslot] <= cs;
      end
   end

   // Column sum memory
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      col_rd_ff <= col_mem[q_ent.x];
   end

   // Row store memory
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= ent_ff.pix;
      end
      row_rd_ff <= row_mem[row_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ test/tb.sv @@
// Testbench for the box filter mean core: directed table and cases, then random frames.
`timescale 1ns / 1ps

module tb;
   import bfm_pkg::*;

   localparam int MAX_W     = DEF_MAX_WIDTH;
   localparam int MAX_WIN   = DEF_MAX_WINDOW;
   localparam int DRAIN_CYC = 200;
   localparam int WDOG_CYC  = 6000;

   typedef struct packed {
      logic [PIX_W-1:0] mean;
      logic             last;
   } mean_rsp_type;

   typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_CHK} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int        a;      // register index, or pixel
      int        b;      // register value, or frame start
      bit        has;    // typed rows: a result is expected
      int        mean;
      bit        last;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [PIX_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   box_filter_mean_core uut (.*);

   // shadow copy of the block state
   logic [WIDTH_W-1:0]  sh_width;
   logic [HEIGHT_W-1:0] sh_height;
   logic [WIN_W-1:0]    sh_window;
   logic [PIX_W-1:0]    line_mem [MAX_WIN*MAX_W];
   logic [CSUM_W-1:0]   col_total [MAX_W];
   logic [CSUM_W-1:0]   recent_cols [MAX_WIN];
   logic [WSUM_W-1:0]   box_total;
   int                  row_pos, col_pos;

   mean_rsp_type mean_q[$];
   int  fail_cnt = 0;
   int  quiet_cyc = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_left = 0;

   function automatic int eff_width();
      if (sh_width == 0) return 1;
      if (sh_width > MAX_W) return MAX_W;
      return sh_width;
   endfunction

   function automatic int eff_height();
      if (sh_height == 0) return 1;
      if (sh_height > MAX_HEIGHT) return MAX_HEIGHT;
      return sh_height;
   endfunction

   // compute the mean for one accepted pixel; returns 1 when a result is due
   function automatic bit box_mean(input logic [7:0] pix, input bit start,
                                   output mean_rsp_type rsp);
      int w, h, win, r, x, slot;
      logic [CSUM_W-1:0] cs;
      int unsigned mean;
      bit due;
      w = eff_width();
      h = eff_height();
      win = (sh_window > MAX_WIN) ? MAX_WIN : sh_window;
      due = 0;
      rsp = '0;
      if (start) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      x = col_pos;
      if (win != 0) begin
         slot = r % win;
         if (r == 0) begin
            cs = pix;
         end else begin
            cs = col_total[x] + pix;
            if (r >= win) cs = cs - line_mem[slot*MAX_W + x];
         end
         col_total[x] = cs;
         line_mem[slot*MAX_W + x] = pix;
         slot = x % win;
         if (x == 0) begin
            box_total = cs;
         end else begin
            box_total = box_total + cs;
            if (x >= win) box_total = box_total - recent_cols[slot];
         end
         recent_cols[slot] = cs;
         if (win <= w && win <= h && r + 1 >= win && x + 1 >= win) begin
            mean = box_total / (win * win);
            if (mean > 255) mean = 255;
            rsp.mean = mean[7:0];
            rsp.last = (r + 1 == h) && (x + 1 == w);
            due = 1;
         end
      end
      if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = x + 1;
      end
      return due;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cyc <= 0;
      else quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= WDOG_CYC) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: stall at random, or hold off for a counted stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // compare each result with the oldest expected mean
   always @(posedge clock) begin
      mean_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mean_q.size() == 0) begin
            $error("unexpected result mean_value=%0d frame_last=%0b", rsp_tdata, rsp_tlast);
            fail_cnt++;
         end else begin
            exp_rsp = mean_q.pop_front();
            if (rsp_tdata !== exp_rsp.mean) begin
               $error("mean_value expected %0d actual %0d", exp_rsp.mean, rsp_tdata);
               fail_cnt++;
            end
            if (rsp_tlast !== exp_rsp.last) begin
               $error("frame_last expected %0b actual %0b", exp_rsp.last, rsp_tlast);
               fail_cnt++;
            end
         end
      end
   end

   // hold the sender until every result is back, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (mean_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic set_reg(input reg_index_type idx, input int val);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      case (idx)
         REG_WIDTH:  sh_width  = val[WIDTH_W-1:0];
         REG_HEIGHT: sh_height = val[HEIGHT_W-1:0];
         REG_WINDOW: sh_window = val[WIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic setup(input int w, input int h, input int win);
      drain();
      set_reg(REG_WIDTH, w);
      set_reg(REG_HEIGHT, h);
      set_reg(REG_WINDOW, win);
   endtask

   // offer one pixel; on accept either push the typed or the predicted mean
   task automatic send_pixel(input int pix, input bit start, input bit typed = 0,
                             input bit t_has = 0, input mean_rsp_type t_rsp = '0);
      mean_rsp_type rsp;
      bit due;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= pix[7:0];
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      due = box_mean(pix[7:0], start, rsp);
      if (typed) begin
         due = t_has;
         rsp = t_rsp;
      end
      if (due) mean_q.push_back(rsp);
   endtask

   // random frames with mostly small sizes and a few extremes
   task automatic run_frames(input int n_items);
      int sent, w, h, win, lim, nfr, len, mode, kind, pix, i, hw;
      bit start, prev_full;
      sent = 0;
      prev_full = 0;
      while (sent < n_items) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         case ($urandom_range(0, 19))
            0: w = 2047;
            1: w = 0;
            2: h = 8191;
            3: h = 0;
            4: w = MAX_W;
            default: ;
         endcase
         hw = (w == 0) ? 1 : (w > MAX_W ? MAX_W : w);
         lim = (h == 0) ? 1 : (h > 15 ? 15 : h);
         if (hw < lim) lim = hw;
         win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                           : $urandom_range(1, lim);
         setup(w, h, win);
         prev_full = 0;
         nfr = $urandom_range(1, 3);
         for (int f = 0; f < nfr; f++) begin
            len = eff_width() * eff_height();
            kind = $urandom_range(0, 19);
            if (kind >= 17 || len > 300) begin
               len = $urandom_range(1, (len > 300) ? 60 : len);
            end
            mode = $urandom_range(0, 7);
            for (i = 0; i < len; i++) begin
               start = (i == 0) && !(prev_full && $urandom_range(0, 3) == 0);
               if (kind == 19 && i != 0) start = ($urandom_range(0, 7) == 0);
               case (mode)
                  0: pix = 255;
                  1: pix = 0;
                  default: pix = $urandom_range(0, 255);
               endcase
               send_pixel(pix, start);
               sent++;
            end
            prev_full = (kind < 17) && (len == eff_width() * eff_height());
         end
      end
   endtask

   stim_row_type dir_tab[] = '{
      '{ROW_CFG, REG_WIDTH, 2, 0, 0, 0}, '{ROW_CFG, REG_HEIGHT, 2, 0, 0, 0},
      '{ROW_CFG, REG_WINDOW, 2, 0, 0, 0},
      '{ROW_PIX_CHK, 255, 1, 0, 0, 0}, '{ROW_PIX_CHK, 255, 0, 0, 0, 0},
      '{ROW_PIX_CHK, 255, 0, 0, 0, 0}, '{ROW_PIX_CHK, 255, 0, 1, 255, 1},
      '{ROW_PIX_CHK, 0, 1, 0, 0, 0}, '{ROW_PIX_CHK, 0, 0, 0, 0, 0},
      '{ROW_PIX_CHK, 0, 0, 0, 0, 0}, '{ROW_PIX_CHK, 0, 0, 1, 0, 1},
      '{ROW_CFG, REG_WIDTH, 1, 0, 0, 0}, '{ROW_CFG, REG_HEIGHT, 1, 0, 0, 0},
      '{ROW_CFG, REG_WINDOW, 1, 0, 0, 0},
      '{ROW_PIX_CHK, 255, 1, 1, 255, 1}, '{ROW_PIX_CHK, 0, 0, 1, 0, 1},
      '{ROW_CFG, REG_WIDTH, 0, 0, 0, 0}, '{ROW_CFG, REG_HEIGHT, 0, 0, 0, 0},
      '{ROW_PIX_CHK, 7, 1, 1, 7, 1},
      '{ROW_CFG, REG_WINDOW, 0, 0, 0, 0},
      '{ROW_PIX_CHK, 9, 1, 0, 0, 0},
      '{ROW_CFG, REG_WIDTH, 3, 0, 0, 0}, '{ROW_CFG, REG_HEIGHT, 3, 0, 0, 0},
      '{ROW_CFG, REG_WINDOW, 15, 0, 0, 0},
      '{ROW_PIX_CHK, 200, 1, 0, 0, 0}, '{ROW_PIX_CHK, 100, 0, 0, 0, 0},
      '{ROW_CFG, REG_HEIGHT, 2, 0, 0, 0}, '{ROW_CFG, REG_WINDOW, 2, 0, 0, 0},
      '{ROW_PIX, 10, 1, 0, 0, 0}, '{ROW_PIX, 20, 0, 0, 0, 0},
      '{ROW_PIX, 30, 1, 0, 0, 0}, '{ROW_PIX, 40, 0, 0, 0, 0},
      '{ROW_PIX, 50, 0, 0, 0, 0}, '{ROW_PIX, 61, 0, 0, 0, 0},
      '{ROW_PIX, 77, 0, 0, 0, 0}, '{ROW_PIX, 93, 0, 0, 0, 0}
   };

   // stimulus
   initial begin
      mean_rsp_type t_rsp;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = 0;
      csr_we     = 0;
      csr_index  = REG_WIDTH;
      csr_wdata  = '0;
      reset      = 1;
      sh_width   = RST_WIDTH;
      sh_height  = RST_HEIGHT;
      sh_window  = RST_WINDOW;
      for (int i = 0; i < MAX_WIN*MAX_W; i++) line_mem[i] = '0;
      for (int i = 0; i < MAX_W; i++) col_total[i] = '0;
      for (int i = 0; i < MAX_WIN; i++) recent_cols[i] = '0;
      box_total = '0;
      row_pos = 0;
      col_pos = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // default registers: one small partial frame
      for (int i = 0; i < 5; i++) send_pixel($urandom_range(0, 255), i == 0);

      // walk the directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CFG) begin
            drain();
            set_reg(reg_index_type'(dir_tab[i].a), dir_tab[i].b);
         end else begin
            t_rsp.mean = dir_tab[i].mean[7:0];
            t_rsp.last = dir_tab[i].last;
            send_pixel(dir_tab[i].a, dir_tab[i].b, dir_tab[i].kind == ROW_PIX_CHK,
                       dir_tab[i].has, t_rsp);
         end
      end

      // shrink the image under a running frame: width, then height
      setup(6, 6, 2);
      for (int i = 0; i < 22; i++) send_pixel($urandom_range(0, 255), i == 0);
      drain();
      set_reg(REG_WIDTH, 3);
      for (int i = 0; i < 6; i++) send_pixel($urandom_range(0, 255), 0);
      drain();
      set_reg(REG_HEIGHT, 2);
      for (int i = 0; i < 8; i++) send_pixel($urandom_range(0, 255), 0);

      // back pressure: long hold-off while pixels keep coming
      setup(8, 8, 2);
      hold_left = 800;
      for (int i = 0; i < 64; i++) send_pixel($urandom_range(0, 255), i == 0);

      // idle phases
      send_idle_pct = 0;  stall_pct = 0;  run_frames(300);
      send_idle_pct = 62; stall_pct = 0;  run_frames(300);
      send_idle_pct = 0;  stall_pct = 62; run_frames(300);
      send_idle_pct = 25; stall_pct = 25; run_frames(300);
      send_idle_pct = 0;  stall_pct = 0;
      drain();

      if (fail_cnt == 0 && mean_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ box_filter_mean_core.f @@
design/bfm_pkg.sv
design/bfm_queue.sv
design/bfm_front.sv
design/bfm_back.sv
design/box_filter_mean_core.sv
test/tb.sv
